// ===== rtl/core/cdf_pkg.sv =====
package cdf_pkg;

    // parser phases
    typedef enum logic [2:0] {
        PH_BASIC,
        PH_EXT_ONE,
        PH_EXT_LO,
        PH_EXT_HI,
        PH_MSGHDR,
        PH_EXTTS,
        PH_PAYLOAD,
        PH_CONT
    } phase_t;

    // result kinds
    typedef enum logic [1:0] {
        KIND_HEADER  = 2'd0,
        KIND_PAYLOAD = 2'd1,
        KIND_ERROR   = 2'd2
    } kind_t;

    // one channel table entry
    typedef struct packed {
        logic [23:0] ts;
        logic [23:0] len;
        logic [7:0]  mtype;
        logic [31:0] stream;
    } entry_t;

    // table write port
    typedef struct packed {
        logic       we;
        logic [5:0] addr;
        entry_t     data;
    } tbl_wr_t;

    // one result transfer
    typedef struct packed {
        kind_t       kind;
        logic [5:0]  channel;
        logic [23:0] timestamp;
        logic [14:0] length;
        logic [7:0]  msg_type;
        logic [31:0] msg_stream;
        logic [7:0]  payload_byte;
        logic        last;
    } result_t;

    localparam logic [15:0] CHUNK_SIZE_RESET = 16'd128;
    localparam logic [23:0] TS_EXTENDED      = 24'hFFFFFF;
    localparam logic [23:0] TYPE0_LEN        = 24'd4;
    localparam logic [1:0]  EXTTS_LAST       = 2'd3;
    localparam logic [5:0]  CH_EXT_ONE       = 6'd0;
    localparam logic [5:0]  CH_EXT_TWO       = 6'd1;

    // message header byte positions
    localparam logic [3:0] IDX_TS_END     = 4'd2;
    localparam logic [3:0] IDX_LEN_END    = 4'd5;
    localparam logic [3:0] IDX_TYPE_END   = 4'd6;
    localparam logic [3:0] IDX_LE_START   = 4'd7;
    localparam logic [3:0] IDX_STREAM_END = 4'd10;

    localparam logic [3:0] HDR_LEN_FMT0 = 4'd11;
    localparam logic [3:0] HDR_LEN_FMT1 = 4'd7;
    localparam logic [3:0] HDR_LEN_FMT2 = 4'd3;
    localparam logic [3:0] HDR_LEN_FMT3 = 4'd0;

    // message header length by header format
    function automatic logic [3:0] hdr_len(input logic [1:0] fmt);
        logic [3:0] n;
        unique case (fmt)
            2'd0: n = HDR_LEN_FMT0;
            2'd1: n = HDR_LEN_FMT1;
            2'd2: n = HDR_LEN_FMT2;
            2'd3: n = HDR_LEN_FMT3;
        endcase
        return n;
    endfunction

endpackage

// ===== rtl/core/cdf_chan_table.sv =====
module cdf_chan_table #(
    parameter int CHANNELS = 64
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic [5:0]      rd_addr,
    input  cdf_pkg::tbl_wr_t wr,
    output cdf_pkg::entry_t rd_data
);

    localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam logic [6:0] CH_LIMIT = 7'(CHANNELS);

    cdf_pkg::entry_t   mem [CHANNELS];
    logic [CHANNELS-1:0] valid_reg;
    cdf_pkg::entry_t   rd_data_reg;

    logic wr_in_range;
    logic rd_in_range;

    assign wr_in_range = ({1'b0, wr.addr} < CH_LIMIT);
    assign rd_in_range = ({1'b0, rd_addr} < CH_LIMIT);

    // write port
    always_ff @(posedge aclk) begin
        if (wr.we && wr_in_range) begin
            mem[wr.addr[AW-1:0]] <= wr.data;
        end
    end

    // per-entry valid bits, unwritten entries read as zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (wr.we && wr_in_range) begin
            valid_reg[wr.addr[AW-1:0]] <= 1'b1;
        end
    end

    // registered read with write forwarding
    always_ff @(posedge aclk) begin
        if (wr.we && (wr.addr == rd_addr)) begin
            rd_data_reg <= wr.data;
        end else if (rd_in_range && valid_reg[rd_addr[AW-1:0]]) begin
            rd_data_reg <= mem[rd_addr[AW-1:0]];
        end else begin
            rd_data_reg <= '0;
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/core/cdf_parser.sv =====
module cdf_parser #(
    parameter int CHANNELS    = 64,
    parameter int MAX_MESSAGE = 32768
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic [15:0]      chunk_size,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [7:0]       s_data_byte,
    output logic [5:0]       rd_addr,
    input  cdf_pkg::entry_t  rd_data,
    output cdf_pkg::tbl_wr_t wr,
    output cdf_pkg::result_t result,
    output logic             m_valid,
    input  logic             m_ready
);

    localparam logic [6:0]  CH_LIMIT  = 7'(CHANNELS);
    localparam logic [24:0] MSG_LIMIT = 25'(MAX_MESSAGE);

    // input stage
    logic       byte_valid_reg;
    logic [7:0] byte_reg;

    // parser state
    cdf_pkg::phase_t phase_reg, phase_next;
    logic [1:0]      fmt_reg, fmt_next;
    logic [5:0]      ch_reg, ch_next;
    logic [3:0]      hidx_reg, hidx_next;
    logic [31:0]     shift_reg, shift_next;
    logic [23:0]     rem_reg, rem_next;
    logic [15:0]     cnt_reg, cnt_next;
    logic [1:0]      skip_reg, skip_next;
    cdf_pkg::entry_t cur_reg, cur_next;

    // output register
    logic             m_valid_reg;
    cdf_pkg::result_t res_reg;
    cdf_pkg::result_t res;
    logic             emit;

    logic advance;
    logic out_ok;

    assign out_ok  = !m_valid_reg || m_ready;
    assign advance = byte_valid_reg && out_ok;
    assign s_ready = !byte_valid_reg || advance;

    // table read for the byte entering the stage, held while stalled
    assign rd_addr = (s_valid && s_ready) ? s_data_byte[5:0] : byte_reg[5:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_valid_reg <= 1'b0;
        end else if (s_ready) begin
            byte_valid_reg <= s_valid;
        end
        if (s_valid && s_ready) begin
            byte_reg <= s_data_byte;
        end
    end

    // next state and result
    always_comb begin
        logic        do_hdr_done;
        logic        do_emit;
        logic [1:0]  lane;
        logic [23:0] rem_hdr;
        logic [23:0] msg_len;

        phase_next  = phase_reg;
        fmt_next    = fmt_reg;
        ch_next     = ch_reg;
        hidx_next   = hidx_reg;
        shift_next  = shift_reg;
        rem_next    = rem_reg;
        cnt_next    = cnt_reg;
        skip_next   = skip_reg;
        cur_next    = cur_reg;
        res         = '0;
        emit        = 1'b0;
        wr          = '0;
        do_hdr_done = 1'b0;
        do_emit     = 1'b0;
        rem_hdr     = '0;
        lane        = 2'(hidx_reg - cdf_pkg::IDX_LE_START);
        msg_len     = (cur_reg.mtype != 8'd0) ? cur_reg.len : cdf_pkg::TYPE0_LEN;

        if (advance) begin
            unique case (phase_reg)
                cdf_pkg::PH_BASIC: begin
                    fmt_next = byte_reg[7:6];
                    ch_next  = byte_reg[5:0];
                    cur_next = rd_data;
                    if (byte_reg[5:0] == cdf_pkg::CH_EXT_ONE) begin
                        phase_next = cdf_pkg::PH_EXT_ONE;
                    end else if (byte_reg[5:0] == cdf_pkg::CH_EXT_TWO) begin
                        phase_next = cdf_pkg::PH_EXT_LO;
                    end else if ({1'b0, byte_reg[5:0]} >= CH_LIMIT) begin
                        emit       = 1'b1;
                        res.kind   = cdf_pkg::KIND_ERROR;
                        phase_next = cdf_pkg::PH_BASIC;
                    end else begin
                        hidx_next  = '0;
                        shift_next = '0;
                        if (cdf_pkg::hdr_len(byte_reg[7:6]) == 4'd0) begin
                            do_hdr_done = 1'b1;
                        end else begin
                            phase_next = cdf_pkg::PH_MSGHDR;
                        end
                    end
                end
                // extended ids are always beyond the table
                cdf_pkg::PH_EXT_ONE, cdf_pkg::PH_EXT_HI: begin
                    emit       = 1'b1;
                    res.kind   = cdf_pkg::KIND_ERROR;
                    phase_next = cdf_pkg::PH_BASIC;
                end
                cdf_pkg::PH_EXT_LO: begin
                    phase_next = cdf_pkg::PH_EXT_HI;
                end
                cdf_pkg::PH_MSGHDR: begin
                    if (hidx_reg < cdf_pkg::IDX_LE_START) begin
                        shift_next = {shift_reg[23:0], byte_reg};
                    end else begin
                        shift_next[8*lane +: 8] = shift_reg[8*lane +: 8] | byte_reg;
                    end
                    if (hidx_reg == cdf_pkg::IDX_TS_END) begin
                        cur_next.ts = shift_next[23:0];
                        shift_next  = '0;
                        wr.we       = 1'b1;
                    end else if (hidx_reg == cdf_pkg::IDX_LEN_END) begin
                        cur_next.len = shift_next[23:0];
                        shift_next   = '0;
                        wr.we        = 1'b1;
                    end else if (hidx_reg == cdf_pkg::IDX_TYPE_END) begin
                        cur_next.mtype = shift_next[7:0];
                        shift_next     = '0;
                        wr.we          = 1'b1;
                    end else if (hidx_reg == cdf_pkg::IDX_STREAM_END) begin
                        cur_next.stream = shift_next;
                        shift_next      = '0;
                        wr.we           = 1'b1;
                    end
                    hidx_next = hidx_reg + 4'd1;
                    if (hidx_next >= cdf_pkg::hdr_len(fmt_reg)) begin
                        do_hdr_done = 1'b1;
                    end
                end
                cdf_pkg::PH_EXTTS: begin
                    if (skip_reg >= cdf_pkg::EXTTS_LAST) begin
                        do_emit = 1'b1;
                    end else begin
                        skip_next = skip_reg + 2'd1;
                    end
                end
                cdf_pkg::PH_PAYLOAD: begin
                    rem_next          = rem_reg - 24'd1;
                    cnt_next          = cnt_reg + 16'd1;
                    emit              = 1'b1;
                    res.kind          = cdf_pkg::KIND_PAYLOAD;
                    res.channel       = ch_reg;
                    res.timestamp     = cur_reg.ts;
                    res.length        = msg_len[14:0];
                    res.msg_type      = cur_reg.mtype;
                    res.msg_stream    = cur_reg.stream;
                    res.payload_byte  = byte_reg;
                    if (rem_next == 24'd0) begin
                        phase_next = cdf_pkg::PH_BASIC;
                        cnt_next   = '0;
                        res.last   = 1'b1;
                    end else if (cur_reg.mtype != 8'd0 && cnt_next >= chunk_size) begin
                        cnt_next   = '0;
                        phase_next = cdf_pkg::PH_CONT;
                    end
                end
                cdf_pkg::PH_CONT: begin
                    phase_next = cdf_pkg::PH_PAYLOAD;
                end
            endcase

            // header complete: size check, extended timestamp, then header result
            if (do_hdr_done) begin
                if ({1'b0, cur_next.len} >= MSG_LIMIT) begin
                    emit           = 1'b1;
                    res.kind       = cdf_pkg::KIND_ERROR;
                    res.channel    = ch_next;
                    res.timestamp  = cur_next.ts;
                    res.msg_type   = cur_next.mtype;
                    res.msg_stream = cur_next.stream;
                    phase_next     = cdf_pkg::PH_BASIC;
                end else if (cur_next.ts == cdf_pkg::TS_EXTENDED) begin
                    skip_next  = '0;
                    phase_next = cdf_pkg::PH_EXTTS;
                end else begin
                    do_emit = 1'b1;
                end
            end

            if (do_emit) begin
                rem_hdr        = (cur_next.mtype != 8'd0) ? cur_next.len
                                                          : cdf_pkg::TYPE0_LEN;
                rem_next       = rem_hdr;
                cnt_next       = '0;
                emit           = 1'b1;
                res.kind       = cdf_pkg::KIND_HEADER;
                res.channel    = ch_next;
                res.timestamp  = cur_next.ts;
                res.length     = rem_hdr[14:0];
                res.msg_type   = cur_next.mtype;
                res.msg_stream = cur_next.stream;
                res.last       = (rem_hdr == 24'd0);
                phase_next     = (rem_hdr != 24'd0) ? cdf_pkg::PH_PAYLOAD
                                                    : cdf_pkg::PH_BASIC;
            end
        end

        wr.addr = ch_reg;
        wr.data = cur_next;
    end

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= cdf_pkg::PH_BASIC;
            hidx_reg  <= '0;
            rem_reg   <= '0;
            cnt_reg   <= '0;
            skip_reg  <= '0;
        end else begin
            phase_reg <= phase_next;
            hidx_reg  <= hidx_next;
            rem_reg   <= rem_next;
            cnt_reg   <= cnt_next;
            skip_reg  <= skip_next;
        end
        fmt_reg   <= fmt_next;
        ch_reg    <= ch_next;
        shift_reg <= shift_next;
        cur_reg   <= cur_next;
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance && emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (advance && emit) begin
            res_reg <= res;
        end
    end

    assign m_valid = m_valid_reg;
    assign result  = res_reg;

    // table is written only while merging a message header
    a_wr_in_msghdr: assert property (@(posedge aclk) disable iff (!aresetn)
        wr.we |-> (phase_reg == cdf_pkg::PH_MSGHDR) && advance)
        else $error("table write outside message header");

    // payload phase always has bytes left
    a_payload_rem: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == cdf_pkg::PH_PAYLOAD) |-> (rem_reg != 24'd0))
        else $error("payload phase with nothing remaining");

    // error results never mark the end of a message
    a_err_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && res_reg.kind == cdf_pkg::KIND_ERROR) |-> !res_reg.last)
        else $error("error result with last set");

    // a stalled byte stays in the stage
    a_byte_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (byte_valid_reg && !advance) |=> byte_valid_reg && $stable(byte_reg))
        else $error("stalled byte lost");

endmodule

// ===== rtl/core/chunk_stream_deframer_unit.sv =====
// Channel   Ports                             Transfer when
// in        s_valid s_ready s_data_byte       s_valid && s_ready
// out       m_valid m_ready m_kind .. m_last  m_valid && m_ready
// config    cfg_wr_en cfg_wr_data             cfg_wr_en
//
// One byte per cycle sustained while the result side accepts; a byte passes
// the input stage, then its result is loaded into the result register.
// The registered channel table read is issued as the byte enters
// the input stage, so a format-3 header resolves without a bubble.
// Reset is synchronous and clears the table valid bits at once; no sweep.
// A stall on the result side holds the input stage and drops s_ready.
module chunk_stream_deframer_unit #(
    parameter int CHANNELS    = 64,
    parameter int MAX_MESSAGE = 32768
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_kind,
    output logic [5:0]  m_channel,
    output logic [23:0] m_timestamp,
    output logic [14:0] m_length,
    output logic [7:0]  m_msg_type,
    output logic [31:0] m_msg_stream,
    output logic [7:0]  m_payload_byte,
    output logic        m_last
);

    logic [15:0]      chunk_size_reg;
    logic [5:0]       rd_addr;
    cdf_pkg::entry_t  rd_data;
    cdf_pkg::tbl_wr_t wr;
    cdf_pkg::result_t result;

    // chunk size register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chunk_size_reg <= cdf_pkg::CHUNK_SIZE_RESET;
        end else if (cfg_wr_en) begin
            chunk_size_reg <= cfg_wr_data;
        end
    end

    cdf_chan_table #(
        .CHANNELS (CHANNELS)
    ) u_table (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_addr (rd_addr),
        .wr      (wr),
        .rd_data (rd_data)
    );

    cdf_parser #(
        .CHANNELS    (CHANNELS),
        .MAX_MESSAGE (MAX_MESSAGE)
    ) u_parser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .chunk_size  (chunk_size_reg),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data_byte (s_data_byte),
        .rd_addr     (rd_addr),
        .rd_data     (rd_data),
        .wr          (wr),
        .result      (result),
        .m_valid     (m_valid),
        .m_ready     (m_ready)
    );

    assign m_kind         = result.kind;
    assign m_channel      = result.channel;
    assign m_timestamp    = result.timestamp;
    assign m_length       = result.length;
    assign m_msg_type     = result.msg_type;
    assign m_msg_stream   = result.msg_stream;
    assign m_payload_byte = result.payload_byte;
    assign m_last         = result.last;

endmodule

// ===== tb/sv/chunk_stream_deframer_unit_test.sv =====
`timescale 1ns / 1ps

module chunk_stream_deframer_unit_test;

    localparam int NUM_CHANNELS = 64;
    localparam int MSG_LIMIT    = 32768;
    localparam int CYCLE_LIMIT  = 100000;
    localparam int DRAIN_CYCLES = 8;
    localparam int ITEMS        = 1250;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [15:0] cfg_wr_data = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_data_byte = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [1:0]  m_kind;
    logic [5:0]  m_channel;
    logic [23:0] m_timestamp;
    logic [14:0] m_length;
    logic [7:0]  m_msg_type;
    logic [31:0] m_msg_stream;
    logic [7:0]  m_payload_byte;
    logic        m_last;

    chunk_stream_deframer_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_data_byte(s_data_byte),
        .m_valid(m_valid), .m_ready(m_ready), .m_kind(m_kind),
        .m_channel(m_channel), .m_timestamp(m_timestamp), .m_length(m_length),
        .m_msg_type(m_msg_type), .m_msg_stream(m_msg_stream),
        .m_payload_byte(m_payload_byte), .m_last(m_last)
    );

    // clock and watchdog
    int cycle_count = 0;
    always #1 aclk = ~aclk;
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("chunk_stream_deframer_unit test failed");
            $finish;
        end
    end

    // deframer state mirror
    cdf_pkg::result_t expected_results[$];
    int               error_count = 0;
    int               bytes_sent = 0;
    cdf_pkg::phase_t  parse_ph;
    logic [1:0]       hdr_fmt;
    int unsigned      cur_chan;
    int unsigned      hdr_idx;
    logic [31:0]      hdr_shift;
    int unsigned      pay_left;
    int unsigned      chunk_cnt;
    int unsigned      skip_cnt;
    int unsigned      chunk_len;
    logic [23:0]      tbl_ts[NUM_CHANNELS];
    logic [23:0]      tbl_len[NUM_CHANNELS];
    logic [7:0]       tbl_type[NUM_CHANNELS];
    logic [31:0]      tbl_stream[NUM_CHANNELS];

    function automatic int unsigned msg_hdr_bytes(input logic [1:0] f);
        case (f)
            2'd0: return 11;
            2'd1: return 7;
            2'd2: return 3;
            default: return 0;
        endcase
    endfunction

    task automatic push_entry(input cdf_pkg::kind_t k, input int unsigned len,
                              input logic [7:0] pb, input logic lst);
        cdf_pkg::result_t r;
        int unsigned c;
        c = cur_chan % NUM_CHANNELS;
        r.kind = k;
        r.channel = c[5:0];
        r.timestamp = tbl_ts[c];
        r.length = len[14:0];
        r.msg_type = tbl_type[c];
        r.msg_stream = tbl_stream[c];
        r.payload_byte = pb;
        r.last = lst;
        expected_results.push_back(r);
    endtask

    task automatic open_message();
        int unsigned c;
        c = cur_chan % NUM_CHANNELS;
        pay_left = (tbl_type[c] != 0) ? tbl_len[c] : 4;
        chunk_cnt = 0;
        push_entry(cdf_pkg::KIND_HEADER, pay_left, 8'h00, pay_left == 0);
        parse_ph = (pay_left != 0) ? cdf_pkg::PH_PAYLOAD : cdf_pkg::PH_BASIC;
    endtask

    task automatic header_complete();
        int unsigned c;
        c = cur_chan % NUM_CHANNELS;
        if (tbl_len[c] >= MSG_LIMIT) begin
            parse_ph = cdf_pkg::PH_BASIC;
            push_entry(cdf_pkg::KIND_ERROR, 0, 8'h00, 1'b0);
        end else if (tbl_ts[c] == 24'hFFFFFF) begin
            skip_cnt = 0;
            parse_ph = cdf_pkg::PH_EXTTS;
        end else begin
            open_message();
        end
    endtask

    task automatic finish_channel();
        cdf_pkg::result_t r;
        if (cur_chan >= NUM_CHANNELS) begin
            parse_ph = cdf_pkg::PH_BASIC;
            r = '0;
            r.kind = cdf_pkg::KIND_ERROR;
            expected_results.push_back(r);
        end else begin
            hdr_idx = 0;
            hdr_shift = '0;
            if (msg_hdr_bytes(hdr_fmt) == 0) header_complete();
            else parse_ph = cdf_pkg::PH_MSGHDR;
        end
    endtask

    // advance the mirror by one accepted byte
    task automatic predict_byte(input logic [7:0] b);
        int unsigned c;
        int unsigned len;
        c = cur_chan % NUM_CHANNELS;
        case (parse_ph)
            cdf_pkg::PH_BASIC: begin
                hdr_fmt = b[7:6];
                cur_chan = b[5:0];
                if (cur_chan == 0) parse_ph = cdf_pkg::PH_EXT_ONE;
                else if (cur_chan == 1) parse_ph = cdf_pkg::PH_EXT_LO;
                else finish_channel();
            end
            cdf_pkg::PH_EXT_ONE: begin
                cur_chan = 64 + b;
                finish_channel();
            end
            cdf_pkg::PH_EXT_LO: begin
                cur_chan = b;
                parse_ph = cdf_pkg::PH_EXT_HI;
            end
            cdf_pkg::PH_EXT_HI: begin
                cur_chan = 64 + cur_chan + (int'(b) << 8);
                finish_channel();
            end
            cdf_pkg::PH_MSGHDR: begin
                if (hdr_idx < 7) hdr_shift = {hdr_shift[23:0], b};
                else hdr_shift = hdr_shift | (32'(b) << (8 * ((hdr_idx - 7) & 3)));
                case (hdr_idx)
                    2: begin tbl_ts[c] = hdr_shift[23:0]; hdr_shift = '0; end
                    5: begin tbl_len[c] = hdr_shift[23:0]; hdr_shift = '0; end
                    6: begin tbl_type[c] = hdr_shift[7:0]; hdr_shift = '0; end
                    10: begin tbl_stream[c] = hdr_shift; hdr_shift = '0; end
                    default: ;
                endcase
                hdr_idx = (hdr_idx + 1) & 15;
                if (hdr_idx >= msg_hdr_bytes(hdr_fmt)) header_complete();
            end
            cdf_pkg::PH_EXTTS: begin
                if (skip_cnt >= 3) open_message();
                else skip_cnt = skip_cnt + 1;
            end
            cdf_pkg::PH_PAYLOAD: begin
                len = (tbl_type[c] != 0) ? tbl_len[c] : 4;
                pay_left = (pay_left - 1) & 24'hFFFFFF;
                chunk_cnt = (chunk_cnt + 1) & 16'hFFFF;
                if (pay_left == 0) begin
                    parse_ph = cdf_pkg::PH_BASIC;
                    chunk_cnt = 0;
                    push_entry(cdf_pkg::KIND_PAYLOAD, len, b, 1'b1);
                end else begin
                    if (tbl_type[c] != 0 && chunk_cnt >= (chunk_len == 0 ? 1 : chunk_len)) begin
                        chunk_cnt = 0;
                        parse_ph = cdf_pkg::PH_CONT;
                    end
                    push_entry(cdf_pkg::KIND_PAYLOAD, len, b, 1'b0);
                end
            end
            cdf_pkg::PH_CONT: parse_ph = cdf_pkg::PH_PAYLOAD;
            default: parse_ph = cdf_pkg::PH_BASIC;
        endcase
    endtask

    // sender: bursts with random gaps, caller is at a rising edge
    int burst_left = 0;
    task automatic send_byte(input logic [7:0] b);
        int gap;
        s_valid <= 1'b1;
        s_data_byte <= b;
        do @(posedge aclk); while (!s_ready);
        predict_byte(b);
        bytes_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(30, 80)
                                                   : $urandom_range(0, 12);
            gap = $urandom_range(1, 4);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // drain the remainder of whatever the parser is in the middle of
    task automatic send_until_resync();
        while (parse_ph != cdf_pkg::PH_BASIC) send_byte(8'($urandom));
    endtask

    task automatic send_message(input logic [1:0] f, input logic [5:0] ch,
                                input logic [23:0] ts, input logic [23:0] len,
                                input logic [7:0] mt, input logic [31:0] sid);
        send_byte({f, ch});
        if (f != 2'd3) begin
            send_byte(ts[23:16]); send_byte(ts[15:8]); send_byte(ts[7:0]);
        end
        if (f <= 2'd1) begin
            send_byte(len[23:16]); send_byte(len[15:8]); send_byte(len[7:0]);
            send_byte(mt);
        end
        if (f == 2'd0) begin
            send_byte(sid[7:0]); send_byte(sid[15:8]);
            send_byte(sid[23:16]); send_byte(sid[31:24]);
        end
        send_until_resync();
    endtask

    task automatic send_random_message();
        logic [23:0] ts;
        logic [23:0] len;
        logic [7:0]  mt;
        ts = ($urandom_range(0, 7) == 0) ? 24'hFFFFFF : 24'($urandom);
        len = ($urandom_range(0, 15) == 0) ? 24'($urandom_range(100, 400))
                                           : 24'($urandom_range(0, 24));
        if ($urandom_range(0, 19) == 0) len = 24'($urandom_range(MSG_LIMIT, 24'hFFFFFF));
        mt = ($urandom_range(0, 5) == 0) ? 8'h00 : 8'($urandom);
        send_message(2'($urandom), 6'($urandom_range(2, 63)), ts, len, mt, $urandom);
    endtask

    // wait for quiet, then write the chunk size register
    task automatic load_chunk_size(input logic [15:0] val);
        s_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        chunk_len = val;
    endtask

    // receiver: stall pattern plus an optional long hold-off
    bit hold_req = 0;
    int hold_cnt = 0;
    int stall_mode = 0;

    function automatic void report_field(input string name, input logic [31:0] exp_v,
                                         input logic [31:0] act_v);
        $display("%0t: mismatch on %s: expected %0h, actual %0h", $time, name, exp_v, act_v);
    endfunction

    always @(posedge aclk) begin
        cdf_pkg::result_t exp_r;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result: expected none, actual kind %0d",
                         $time, m_kind);
                error_count++;
            end else begin
                exp_r = expected_results.pop_front();
                if ({m_kind, m_channel, m_timestamp, m_length, m_msg_type, m_msg_stream,
                     m_payload_byte, m_last} !== exp_r) begin
                    error_count++;
                    if (m_kind !== exp_r.kind) report_field("kind", exp_r.kind, m_kind);
                    if (m_channel !== exp_r.channel)
                        report_field("channel", exp_r.channel, m_channel);
                    if (m_timestamp !== exp_r.timestamp)
                        report_field("timestamp", exp_r.timestamp, m_timestamp);
                    if (m_length !== exp_r.length)
                        report_field("length", exp_r.length, m_length);
                    if (m_msg_type !== exp_r.msg_type)
                        report_field("msg_type", exp_r.msg_type, m_msg_type);
                    if (m_msg_stream !== exp_r.msg_stream)
                        report_field("msg_stream", exp_r.msg_stream, m_msg_stream);
                    if (m_payload_byte !== exp_r.payload_byte)
                        report_field("payload_byte", exp_r.payload_byte, m_payload_byte);
                    if (m_last !== exp_r.last) report_field("last", exp_r.last, m_last);
                end
            end
        end
        if (hold_req) begin
            hold_req = 0;
            hold_cnt = 400;
        end
        if (cycle_count % 64 == 0) stall_mode = $urandom_range(0, 2);
        if (hold_cnt > 0) begin
            hold_cnt--;
            m_ready <= 1'b0;
        end else begin
            case (stall_mode)
                0: m_ready <= 1'b1;
                1: m_ready <= $urandom_range(0, 1);
                default: m_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // extremes of each header format, special cases
    task automatic test_directed_messages();
        send_message(2'd0, 6'd2, 24'h000000, 24'd0, 8'h00, 32'h0);
        send_message(2'd0, 6'd63, 24'hFFFFFE, 24'd5, 8'hFF, 32'hFFFFFFFF);
        send_message(2'd1, 6'd63, 24'h123456, 24'd3, 8'h14, 32'h0);
        send_message(2'd2, 6'd63, 24'hFFFFFF, 24'd0, 8'h00, 32'h0);
        send_message(2'd3, 6'd63, 24'h0, 24'd0, 8'h00, 32'h0);
        send_message(2'd0, 6'd10, 24'h000001, 24'd0, 8'h09, 32'h01020304);
        // largest legal length, type 0 keeps the payload at four bytes
        send_message(2'd1, 6'd11, 24'h000002, 24'd32767, 8'h00, 32'h0);
        send_message(2'd1, 6'd12, 24'h000003, 24'h008000, 8'h08, 32'h0);
        send_message(2'd0, 6'd13, 24'h000004, 24'hFFFFFF, 8'h01, 32'hA5A5A5A5);
        send_message(2'd1, 6'd14, 24'h0, 24'd0, 8'h12, 32'h0);
    endtask

    // extended channel ids are all out of range
    task automatic test_bad_channels();
        send_byte({2'd0, cdf_pkg::CH_EXT_ONE}); send_byte(8'h00);
        send_byte({2'd3, cdf_pkg::CH_EXT_ONE}); send_byte(8'hFF);
        send_byte({2'd1, cdf_pkg::CH_EXT_TWO}); send_byte(8'h00); send_byte(8'h00);
        send_byte({2'd2, cdf_pkg::CH_EXT_TWO}); send_byte(8'hFF); send_byte(8'hFF);
    endtask

    // continuation headers at several chunk sizes
    task automatic test_chunk_sizes();
        load_chunk_size(16'd1);
        send_message(2'd1, 6'd20, 24'h10, 24'd6, 8'h09, 32'h0);
        load_chunk_size(16'd3);
        send_message(2'd1, 6'd21, 24'h11, 24'd10, 8'h09, 32'h0);
        send_message(2'd1, 6'd22, 24'h12, 24'd7, 8'h00, 32'h0);
        load_chunk_size(16'hFFFF);
        send_message(2'd1, 6'd23, 24'h13, 24'd150, 8'h09, 32'h0);
        load_chunk_size(cdf_pkg::CHUNK_SIZE_RESET);
        send_message(2'd1, 6'd24, 24'h14, 24'd150, 8'h09, 32'h0);
    endtask

    // long receiver hold-off while the sender keeps offering bytes
    task automatic test_backpressure();
        hold_req = 1;
        repeat (5) send_message(2'd1, 6'd30, 24'h20, 24'd20, 8'h09, 32'h0);
    endtask

    task automatic test_random_traffic();
        int sel;
        logic [15:0] sizes[6] = '{16'd1, 16'd2, 16'd5, 16'd16, 16'd128, 16'hFFFF};
        while (bytes_sent < ITEMS) begin
            if ($urandom_range(0, 60) == 0) begin
                if ($urandom_range(0, 2) == 0) load_chunk_size(16'($urandom_range(1, 65535)));
                else load_chunk_size(sizes[$urandom_range(0, 5)]);
            end
            sel = $urandom_range(0, 99);
            if (sel < 85) begin
                send_random_message();
            end else if (sel < 95) begin
                if ($urandom_range(0, 1) == 0) begin
                    send_byte({2'($urandom), cdf_pkg::CH_EXT_ONE});
                    send_byte(8'($urandom));
                end else begin
                    send_byte({2'($urandom), cdf_pkg::CH_EXT_TWO});
                    send_byte(8'($urandom)); send_byte(8'($urandom));
                end
            end else begin
                repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
                send_until_resync();
            end
        end
    endtask

    initial begin
        chunk_len = cdf_pkg::CHUNK_SIZE_RESET;
        parse_ph = cdf_pkg::PH_BASIC;
        hdr_fmt = '0;
        cur_chan = 0;
        hdr_idx = 0;
        hdr_shift = '0;
        pay_left = 0;
        chunk_cnt = 0;
        skip_cnt = 0;
        foreach (tbl_ts[i]) begin
            tbl_ts[i] = '0;
            tbl_len[i] = '0;
            tbl_type[i] = '0;
            tbl_stream[i] = '0;
        end
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_messages();
        test_bad_channels();
        test_chunk_sizes();
        test_backpressure();
        test_random_traffic();

        // drain and settle
        s_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0 && expected_results.size() == 0) begin
            $display("chunk_stream_deframer_unit test passed");
        end else begin
            $display("chunk_stream_deframer_unit test failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/cdf_pkg.sv
rtl/core/cdf_chan_table.sv
rtl/core/cdf_parser.sv
rtl/core/chunk_stream_deframer_unit.sv
tb/sv/chunk_stream_deframer_unit_test.sv
